### src/bdlp_pkg.sv
// Package for the button debouncer with long-press detection.
// Holds the phase type, event struct, register index codes, reset values and field widths.
// No dependencies.
package bdlp_pkg;

  // Field widths fixed by the register map and the sample format.
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Reset values of the timing registers, in milliseconds.
  localparam logic [DELAY_W-1:0] PRESS_DEB_RST   = 16'd75;
  localparam logic [DELAY_W-1:0] RELEASE_DEB_RST = 16'd175;
  localparam logic [DELAY_W-1:0] LONG_PRESS_RST  = 16'd700;
  localparam logic [DELAY_W-1:0] TOGGLE_REST_RST = 16'd500;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESS_DEB   = 3'd0,
    REG_RELEASE_DEB = 3'd1,
    REG_LONG_PRESS  = 3'd2,
    REG_TOGGLE_REST = 3'd3,
    REG_TOGGLE_MODE = 3'd4,
    REG_ACTIVE_LVL  = 3'd5
  } cfg_reg_t;

  // Debounce machine phases.
  typedef enum logic [1:0] {
    PH_WAIT      = 2'd0,
    PH_PRESS_DEB = 2'd1,
    PH_HELD      = 2'd2,
    PH_REL_DEB   = 2'd3
  } phase_t;

  // Events raised by one sample.
  typedef struct packed {
    logic press;
    logic release_ev;
    logic long_press;
  } events_t;

endpackage

### src/button_debounce_long_press_core.sv
// Top level of the button debouncer with press, release and long-press events.
// Depends on bdlp_pkg for the phase type, event struct, register codes, reset values and widths.
//
//  channel | signals                                   | direction | handshake
//  --------+-------------------------------------------+-----------+----------------
//  in      | in_pin_level, in_now_ms                   | input     | valid/ready
//  out     | out_engaged, out_press_event,             | output    | valid/ready
//          | out_release_event, out_long_press_event   |           |
//  cfg     | cfg_index, cfg_wdata                      | input     | cfg_we, no wait
//
// Each sample is evaluated against the phase state and the result word is
// loaded into the output register on the accepting edge.
// One word per cycle is sustained while out_ready stays high; when the output
// register is full and not taken, in_ready drops until it drains.
// Reset (rst_n low, synchronous) restores the register map defaults and the
// waiting phase, and empties the output register.
module button_debounce_long_press_core (
  input  logic        clk,
  input  logic        rst_n,
  // Sample channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_pin_level,
  input  logic [31:0] in_now_ms,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_engaged,
  output logic        out_press_event,
  output logic        out_release_event,
  output logic        out_long_press_event,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  // Configuration registers.
  logic [bdlp_pkg::DELAY_W-1:0] press_deb_r;
  logic [bdlp_pkg::DELAY_W-1:0] release_deb_r;
  logic [bdlp_pkg::DELAY_W-1:0] long_press_r;
  logic [bdlp_pkg::DELAY_W-1:0] toggle_rest_r;
  logic                         toggle_mode_r;
  logic                         active_level_r;

  // Machine state. The press time equals the edge time for as long as the
  // button is held, so one timestamp serves both.
  bdlp_pkg::phase_t             phase_r, phase_nxt;
  logic [bdlp_pkg::TIME_W-1:0]  edge_time_r, edge_time_nxt;
  logic                         long_rep_r, long_rep_nxt;
  logic                         engaged_r, engaged_nxt;
  logic                         cur_active_r, cur_active_nxt;

  // Output register.
  logic                         out_valid_r;
  logic                         engaged_out_r;
  bdlp_pkg::events_t            events_r, events_nxt;

  logic                         accept;
  logic [bdlp_pkg::TIME_W-1:0]  elapsed;
  logic                         press_deb_done;
  logic                         release_deb_done;
  logic                         long_due;
  logic                         rest_due;
  logic                         active_now;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Wrapped time since the last edge and the strict threshold tests.
  assign elapsed          = in_now_ms - edge_time_r;
  assign press_deb_done   = elapsed > {16'd0, press_deb_r};
  assign release_deb_done = elapsed > {16'd0, release_deb_r};
  assign long_due         = elapsed > {16'd0, long_press_r};
  assign rest_due         = elapsed > {16'd0, toggle_rest_r};

  // In toggle mode the active level flips once the rest time has passed.
  assign active_now = (toggle_mode_r && rest_due) ? !cur_active_r : cur_active_r;

  // Next-state logic.
  always_comb begin
    phase_nxt      = phase_r;
    edge_time_nxt  = edge_time_r;
    long_rep_nxt   = long_rep_r;
    engaged_nxt    = engaged_r;
    cur_active_nxt = cur_active_r;
    unique case (phase_r)
      bdlp_pkg::PH_WAIT: begin
        if (in_pin_level == cur_active_r) begin
          phase_nxt     = bdlp_pkg::PH_PRESS_DEB;
          edge_time_nxt = in_now_ms;
          long_rep_nxt  = 1'b0;
          engaged_nxt   = 1'b1;
        end
      end
      bdlp_pkg::PH_PRESS_DEB: begin
        if (press_deb_done) begin
          phase_nxt = bdlp_pkg::PH_HELD;
        end
      end
      bdlp_pkg::PH_HELD: begin
        cur_active_nxt = active_now;
        if (!toggle_mode_r && long_due) begin
          long_rep_nxt = 1'b1;
        end
        if (in_pin_level != active_now) begin
          phase_nxt     = bdlp_pkg::PH_REL_DEB;
          edge_time_nxt = in_now_ms;
          engaged_nxt   = 1'b0;
        end
      end
      bdlp_pkg::PH_REL_DEB: begin
        if (release_deb_done) begin
          phase_nxt = bdlp_pkg::PH_WAIT;
        end
      end
      default: begin
        phase_nxt = bdlp_pkg::PH_WAIT;
      end
    endcase
  end

  // Event outputs of the current sample.
  always_comb begin
    events_nxt = '0;
    unique case (phase_r)
      bdlp_pkg::PH_WAIT: begin
        events_nxt.press = (in_pin_level == cur_active_r);
      end
      bdlp_pkg::PH_HELD: begin
        events_nxt.long_press = !toggle_mode_r && long_due && !long_rep_r;
        events_nxt.release_ev = (in_pin_level != active_now);
      end
      default: begin
        events_nxt = '0;
      end
    endcase
  end

  // Configuration registers; a write of the active level also reloads the
  // level currently regarded as pressed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_deb_r    <= bdlp_pkg::PRESS_DEB_RST;
      release_deb_r  <= bdlp_pkg::RELEASE_DEB_RST;
      long_press_r   <= bdlp_pkg::LONG_PRESS_RST;
      toggle_rest_r  <= bdlp_pkg::TOGGLE_REST_RST;
      toggle_mode_r  <= 1'b0;
      active_level_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bdlp_pkg::REG_PRESS_DEB:   press_deb_r    <= cfg_wdata;
        bdlp_pkg::REG_RELEASE_DEB: release_deb_r  <= cfg_wdata;
        bdlp_pkg::REG_LONG_PRESS:  long_press_r   <= cfg_wdata;
        bdlp_pkg::REG_TOGGLE_REST: toggle_rest_r  <= cfg_wdata;
        bdlp_pkg::REG_TOGGLE_MODE: toggle_mode_r  <= cfg_wdata[0];
        bdlp_pkg::REG_ACTIVE_LVL:  active_level_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Machine state, updated on each accepted sample; an active level write also loads the pressed level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= bdlp_pkg::PH_WAIT;
      edge_time_r  <= '0;
      long_rep_r   <= 1'b0;
      engaged_r    <= 1'b0;
      cur_active_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        edge_time_r <= edge_time_nxt;
        long_rep_r  <= long_rep_nxt;
        engaged_r   <= engaged_nxt;
      end
      if (cfg_we && (cfg_index == bdlp_pkg::REG_ACTIVE_LVL)) begin
        cur_active_r <= cfg_wdata[0];
      end else if (accept) begin
        cur_active_r <= cur_active_nxt;
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      engaged_out_r <= engaged_nxt;
      events_r      <= events_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_engaged          = engaged_out_r;
  assign out_press_event      = events_r.press;
  assign out_release_event    = events_r.release_ev;
  assign out_long_press_event = events_r.long_press;

  // The active level register is kept for the register map; its value is
  // carried by the pressed-level state from the write onward.
  logic unused_active_level;
  assign unused_active_level = active_level_r;

endmodule

### src/bdlp_checker.sv
// Port-level checker for the button debouncer and its bind to the top level.
// Depends only on the ports of button_debounce_long_press_core.
module bdlp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_engaged,
  input logic out_press_event,
  input logic out_release_event,
  input logic out_long_press_event
);

  // Input side is never blocked while the output register is empty.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output register");

  // A press and a release never come from the same sample.
  a_press_release_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_press_event && out_release_event))
    else $error("press and release in one word");

  // A press leaves the button engaged.
  a_press_engaged: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_press_event) |-> out_engaged)
    else $error("press event without engaged");

  // A release leaves the button disengaged.
  a_release_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_release_event) |-> !out_engaged)
    else $error("release event while engaged");

  // A long press never coincides with the press that started the hold.
  a_long_not_press: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_long_press_event) |-> !out_press_event)
    else $error("long press in the same word as press");

endmodule

bind button_debounce_long_press_core bdlp_checker u_bdlp_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_engaged          (out_engaged),
  .out_press_event      (out_press_event),
  .out_release_event    (out_release_event),
  .out_long_press_event (out_long_press_event)
);
